// ----- src/mse_pkg.sv -----
// Package for the matrix stack engine: sizes, command and status codes, types, identity helper.
// No dependencies.
package mse_pkg;
    localparam int STACK_LEVELS = 32;
    localparam int NUM_STACKS   = 3;
    localparam int FRAC_BITS    = 16;
    localparam int ELEMS        = 16;
    localparam int LVL_W        = $clog2(STACK_LEVELS);
    localparam int SEL_W        = 2;
    localparam int ADDR_W       = SEL_W + LVL_W + 4;
    localparam int DEPTH_OUT_W  = 5;

    typedef enum logic [2:0] {
        CMD_PUSH = 3'd0, CMD_POP = 3'd1, CMD_IDENT = 3'd2, CMD_WTOP = 3'd3,
        CMD_WOPD = 3'd4, CMD_MUL = 3'd5, CMD_READ = 3'd6, CMD_NOP = 3'd7
    } t_cmd;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_UNDF  = 2'd2;

    function automatic logic [31:0] ident_word(input logic [3:0] e);
        ident_word = (e == 4'd0 || e == 4'd5 || e == 4'd10 || e == 4'd15)
                   ? (32'd1 << FRAC_BITS) : 32'd0;
    endfunction
endpackage

// ----- src/matrix_stack_engine_unit.sv -----
// Top level of the matrix stack engine: sequencer, matrix memory, operand store.
// Depends on mse_pkg and mse_mac.
//
// One command is taken at a time. Write top, write operand, pop, unused codes,
// a full-stack push and any stackless select go straight to the result
// handshake; read first reads the element; identity walks the sixteen elements
// through the single memory port; push copies them up a level, a read and a
// write each; multiply fetches each row, runs sixteen dot products through the
// shared MAC and writes back the sixteen results. The sequencer passes through
// idle before taking the next item. After reset a clearing pass writes all
// NUM_STACKS*STACK_LEVELS*16 words (1536) of the store before any item.
module matrix_stack_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [1:0]  i_stack_select,
    input  logic [3:0]  i_element_index,
    input  logic signed [31:0] i_element_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_read_value,
    output logic [4:0]  o_stack_depth,
    output logic [1:0]  o_status
);
    import mse_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DEC, S_RD, S_RDW, S_CPY_R, S_CPY_W, S_IDN,
        S_MUL_A, S_MUL_W, S_MUL_S, S_OUT
    } t_state;

    localparam int CLR_W = ADDR_W;

    t_state            r_state;
    logic [ADDR_W-1:0] r_clr;
    logic [31:0]       mem [NUM_STACKS*STACK_LEVELS*ELEMS];
    logic [31:0]       r_rdata;
    logic [31:0]       r_opd [ELEMS];
    logic [31:0]       r_row [4];
    logic [31:0]       r_res [ELEMS];
    logic [LVL_W-1:0]  r_depth [NUM_STACKS];
    t_cmd              r_cmd;
    logic [1:0]        r_sel;
    logic [3:0]        r_idx;
    logic [3:0]        r_e;
    logic [2:0]        r_k;
    logic [1:0]        r_j;

    logic              w_we;
    logic [ADDR_W-1:0] w_wa, w_ra;
    logic [31:0]       w_wd;
    logic [LVL_W-1:0]  w_top;
    logic              w_mac_clr, w_mac_en, w_mac_acc;
    logic [31:0]       w_sat;

    function automatic logic [ADDR_W-1:0] addr(input logic [1:0] s,
        input logic [LVL_W-1:0] l, input logic [3:0] e);
        addr = {s, l, e};
    endfunction

    assign w_top = r_depth[r_sel];

    mse_mac u_mac (
        .i_clk(i_clk), .i_clr(w_mac_clr), .i_en(w_mac_en),
        .i_a(r_row[r_k[1:0]]), .i_b(r_opd[{r_k[1:0], r_j}]),
        .i_acc(w_mac_acc), .o_sat(w_sat)
    );

    // memory port and MAC control
    always_comb begin
        w_we = 1'b0; w_wa = addr(r_sel, w_top, r_e); w_wd = r_rdata;
        w_ra = addr(r_sel, w_top, r_e);
        w_mac_clr = 1'b0; w_mac_en = 1'b0; w_mac_acc = 1'b0;
        case (r_state)
            S_CLR: begin
                w_we = 1'b1; w_wa = r_clr;
                w_wd = (r_clr[CLR_W-SEL_W-1:4] == '0) ? ident_word(r_clr[3:0]) : 32'd0;
            end
            S_DEC, S_RD: w_ra = addr(r_sel, w_top, r_idx);
            S_CPY_W: begin
                // only push copies up a level; multiply just fetches the row
                w_we = (r_cmd == CMD_PUSH);
                w_wa = addr(r_sel, w_top + LVL_W'(1), r_e);
            end
            S_IDN: begin w_we = 1'b1; w_wd = ident_word(r_e); end
            S_MUL_A: begin
                w_mac_en = (r_k < 3'd4);
                w_mac_acc = (r_k != 3'd0);
                w_mac_clr = (r_k == 3'd0);
            end
            S_MUL_S: begin
                w_we = 1'b1; w_wa = addr(r_sel, w_top, r_e); w_wd = r_res[r_e];
            end
            default: ;
        endcase
        if (r_state == S_IDLE && i_valid && t_cmd'(i_command) == CMD_WTOP
            && i_stack_select < SEL_W'(NUM_STACKS)) begin
            w_we = 1'b1;
            w_wa = addr(i_stack_select, r_depth[i_stack_select], i_element_index);
            w_wd = i_element_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_wa] <= w_wd;
        r_rdata <= mem[w_ra];
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            o_valid <= 1'b0;
            for (int s = 0; s < NUM_STACKS; s++) r_depth[s] <= '0;
            for (int e = 0; e < ELEMS; e++) r_opd[e] <= '0;
        end else begin
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == ADDR_W'(NUM_STACKS*STACK_LEVELS*ELEMS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (i_valid) begin
                    r_cmd <= t_cmd'(i_command); r_sel <= i_stack_select;
                    r_idx <= i_element_index;
                    r_e <= '0; r_k <= '0; r_j <= '0;
                    if (t_cmd'(i_command) == CMD_WOPD) r_opd[i_element_index] <= i_element_value;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    o_read_value <= '0;
                    if (r_sel >= SEL_W'(NUM_STACKS)) begin
                        o_stack_depth <= '0; o_status <= ST_OK; r_state <= S_OUT;
                    end else begin
                        case (r_cmd)
                            CMD_PUSH: begin
                                o_stack_depth <= DEPTH_OUT_W'(w_top);
                                if (w_top == LVL_W'(STACK_LEVELS-1)) begin
                                    o_status <= ST_OVF; r_state <= S_OUT;
                                end else begin
                                    o_status <= ST_OK; r_state <= S_CPY_R;
                                end
                            end
                            CMD_POP: begin
                                if (w_top == '0) begin
                                    o_status <= ST_UNDF;
                                    o_stack_depth <= DEPTH_OUT_W'(w_top);
                                end else begin
                                    o_status <= ST_OK;
                                    r_depth[r_sel] <= w_top - LVL_W'(1);
                                    o_stack_depth <= DEPTH_OUT_W'(w_top - LVL_W'(1));
                                end
                                r_state <= S_OUT;
                            end
                            CMD_IDENT: begin
                                o_status <= ST_OK; o_stack_depth <= DEPTH_OUT_W'(w_top);
                                r_state <= S_IDN;
                            end
                            CMD_MUL: begin
                                o_status <= ST_OK; o_stack_depth <= DEPTH_OUT_W'(w_top);
                                r_state <= S_CPY_R;
                            end
                            CMD_READ: begin
                                o_status <= ST_OK; o_stack_depth <= DEPTH_OUT_W'(w_top);
                                r_state <= S_RD;
                            end
                            default: begin
                                o_status <= ST_OK; o_stack_depth <= DEPTH_OUT_W'(w_top);
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_RD: r_state <= S_RDW;
                S_RDW: begin o_read_value <= r_rdata; r_state <= S_OUT; end
                S_CPY_R: r_state <= S_CPY_W;  // address r_e presented, data next
                S_CPY_W: begin
                    if (r_cmd == CMD_MUL) r_row[r_e[1:0]] <= r_rdata;
                    if (r_cmd == CMD_MUL && r_e[1:0] == 2'd3) begin
                        r_k <= '0; r_j <= '0; r_state <= S_MUL_A;
                    end else if (r_e == 4'd15) begin
                        r_depth[r_sel] <= w_top + LVL_W'(1);
                        o_stack_depth <= DEPTH_OUT_W'(w_top + LVL_W'(1));
                        r_state <= S_OUT;
                    end else begin
                        r_e <= r_e + 4'd1; r_state <= S_CPY_R;
                    end
                end
                S_IDN: begin
                    r_e <= r_e + 4'd1;
                    if (r_e == 4'd15) r_state <= S_OUT;
                end
                S_MUL_A: begin
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd4) r_state <= S_MUL_W;
                end
                S_MUL_W: begin
                    r_res[{r_e[3:2], r_j}] <= w_sat;
                    r_k <= '0; r_j <= r_j + 2'd1;
                    if (r_j != 2'd3) r_state <= S_MUL_A;
                    else if (r_e == 4'd15) begin r_e <= '0; r_state <= S_MUL_S; end
                    else begin r_e <= r_e + 4'd1; r_state <= S_CPY_R; end
                end
                S_MUL_S: begin
                    r_e <= r_e + 4'd1;
                    if (r_e == 4'd15) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_valid && !i_stall) begin
                        o_valid <= 1'b0; r_state <= S_IDLE;
                    end else o_valid <= 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- src/mse_mac.sv -----
// Shared multiply-accumulate unit: one 32x32 product per cycle while enabled, summed over four.
// Depends on mse_pkg.
module mse_mac (
    input  logic        i_clk,
    input  logic        i_clr,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic        i_acc,
    output logic [31:0] o_sat
);
    import mse_pkg::*;
    logic signed [63:0] r_prod;
    logic signed [65:0] r_sum;
    logic signed [65:0] w_sh;

    always_ff @(posedge i_clk) begin
        if (i_en) r_prod <= $signed(i_a) * $signed(i_b);
        if (i_clr) r_sum <= '0;
        else if (i_acc) r_sum <= r_sum + 66'(r_prod);
    end

    // floor of the exact four-term sum, then clamp to 32 bits
    assign w_sh = r_sum >>> FRAC_BITS;
    always_comb begin
        if (w_sh > 66'sh7FFFFFFF) o_sat = 32'h7FFFFFFF;
        else if (w_sh < -66'sh80000000) o_sat = 32'h80000000;
        else o_sat = w_sh[31:0];
    end
endmodule
